// ===== design/cmoi_pkg.sv =====
`default_nettype none
package cmoi_pkg;

  // Field and register widths.
  localparam int unsigned COST_W  = 8;
  localparam int unsigned COORD_W = 6;
  localparam int unsigned RES_W   = 10;
  localparam int unsigned LEN_W   = 14;
  localparam int unsigned GRID_W  = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 14;

  // Default sizes.
  localparam int unsigned DEF_MAX_WIDTH  = 64;
  localparam int unsigned DEF_MAX_HEIGHT = 64;
  localparam int unsigned DEF_MAX_RADIUS = 8;

  // Cost curve constants.
  localparam logic [COST_W-1:0] COST_LETHAL = 8'd255;
  localparam logic [COST_W-1:0] COST_FREE   = 8'd0;
  localparam logic [COST_W-1:0] COST_BASE   = 8'd32;
  localparam int unsigned       COST_SPAN   = 210;

  // Operation codes.
  typedef enum logic [1:0] {
    FN_MARK    = 2'd0,
    FN_CLEAR   = 2'd1,
    FN_INFLATE = 2'd2,
    FN_READ    = 2'd3
  } func_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INFLATION   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INSCRIBED   = 3'd4;

endpackage
`default_nettype wire

// ===== design/cmoi_grid_mem.sv =====
`default_nettype none
module cmoi_grid_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic                       clk,
  input  wire logic                       occ_we,
  input  wire logic [AW-1:0]              occ_wa,
  input  wire logic                       occ_wd,
  input  wire logic [AW-1:0]              occ_ra,
  output logic                            occ_rd,
  input  wire logic                       cost_we,
  input  wire logic [AW-1:0]              cost_wa,
  input  wire logic [cmoi_pkg::COST_W-1:0] cost_wd,
  input  wire logic [AW-1:0]              cost_ra,
  output logic [cmoi_pkg::COST_W-1:0]     cost_rd
);

  logic                        occ_mem  [DEPTH];
  logic [cmoi_pkg::COST_W-1:0] cost_mem [DEPTH];
  logic                        occ_rd_r;
  logic [cmoi_pkg::COST_W-1:0] cost_rd_r;

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    occ_rd_r <= occ_mem[occ_ra];
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_wa] <= cost_wd;
    end
    cost_rd_r <= cost_mem[cost_ra];
  end

  assign occ_rd  = occ_rd_r;
  assign cost_rd = cost_rd_r;

endmodule
`default_nettype wire

// ===== design/cmoi_ring_lut.sv =====
`default_nettype none
module cmoi_ring_lut #(
  parameter int unsigned MAX_RADIUS = cmoi_pkg::DEF_MAX_RADIUS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [cmoi_pkg::RES_W-1:0]    res,
  input  wire logic [cmoi_pkg::LEN_W-1:0]    infl,
  input  wire logic [cmoi_pkg::LEN_W-1:0]    ins,
  output logic                               done,
  output logic [$clog2(MAX_RADIUS+1)-1:0]    radius,
  input  wire logic [$clog2(2*MAX_RADIUS*MAX_RADIUS+1)-1:0] rd_addr,
  output logic [cmoi_pkg::COST_W-1:0]        rd_data
);

  localparam int unsigned RW   = $clog2(MAX_RADIUS+1);
  localparam int unsigned TDEP = 2*MAX_RADIUS*MAX_RADIUS + 1;
  localparam int unsigned TW   = $clog2(TDEP);
  localparam int unsigned SQW  = 2*cmoi_pkg::RES_W;
  localparam int unsigned VW   = TW + SQW;
  localparam int unsigned DW   = (VW + 1) / 2;
  localparam int unsigned QW   = 2*DW;
  localparam int unsigned CW   = $clog2(DW);
  localparam int unsigned ACW  = cmoi_pkg::LEN_W + 1;
  localparam int unsigned NW   = cmoi_pkg::LEN_W + 8;

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_RAD  = 7'b0000010,
    B_MUL  = 7'b0000100,
    B_SQRT = 7'b0001000,
    B_COST = 7'b0010000,
    B_DIV  = 7'b0100000,
    B_WR   = 7'b1000000
  } bstate_t;

  bstate_t                    st_r, st_nxt;
  logic [SQW-1:0]             resq_r, resq_nxt;
  logic [ACW-1:0]             acc_r, acc_nxt;
  logic [RW-1:0]              rad_r, rad_nxt;
  logic [TW-1:0]              s_r, s_nxt, smax_r, smax_nxt;
  logic [QW-1:0]              v_r, v_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [NW-1:0]              num_r, num_nxt, den_r, den_nxt;
  logic [2:0]                 k_r, k_nxt;
  logic [7:0]                 q_r, q_nxt;
  logic [cmoi_pkg::COST_W-1:0] c_r, c_nxt;
  logic                       done_r, done_nxt;
  logic [cmoi_pkg::COST_W-1:0] tab [TDEP];
  logic [cmoi_pkg::COST_W-1:0] rd_data_r;
  logic [QW-1:0]              trial;
  logic [QW-1:0]              d;

  assign trial = root_r + bit_r;
  assign d     = root_r;

  always_comb begin
    st_nxt   = st_r;
    resq_nxt = resq_r;
    acc_nxt  = acc_r;
    rad_nxt  = rad_r;
    s_nxt    = s_r;
    smax_nxt = smax_r;
    v_nxt    = v_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    k_nxt    = k_r;
    q_nxt    = q_r;
    c_nxt    = c_r;
    done_nxt = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (start) begin
          resq_nxt = SQW'(res) * SQW'(res);
          acc_nxt  = '0;
          rad_nxt  = '0;
          st_nxt   = B_RAD;
        end
      end
      B_RAD: begin
        // Smallest radius in cells that covers the inflation distance, capped at MAX_RADIUS.
        if (acc_r >= ACW'(infl) || 32'(rad_r) == MAX_RADIUS) begin
          smax_nxt = TW'(2 * 32'(rad_r) * 32'(rad_r));
          s_nxt    = '0;
          st_nxt   = B_MUL;
        end else begin
          acc_nxt = acc_r + ACW'(res);
          rad_nxt = rad_r + RW'(1);
        end
      end
      B_MUL: begin
        v_nxt    = QW'(s_r) * QW'(resq_r);
        root_nxt = '0;
        bit_nxt  = QW'(1) << (QW - 2);
        cnt_nxt  = '0;
        st_nxt   = B_SQRT;
      end
      B_SQRT: begin
        if (v_r >= trial) begin
          v_nxt    = v_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + CW'(1);
        if (32'(cnt_r) == DW - 1) begin
          st_nxt = B_COST;
        end
      end
      B_COST: begin
        if (d > QW'(infl)) begin
          c_nxt  = cmoi_pkg::COST_FREE;
          st_nxt = B_WR;
        end else if (d <= QW'(ins)) begin
          c_nxt  = cmoi_pkg::COST_LETHAL;
          st_nxt = B_WR;
        end else if (infl <= ins || d >= QW'(infl)) begin
          c_nxt  = cmoi_pkg::COST_FREE;
          st_nxt = B_WR;
        end else begin
          num_nxt = NW'(cmoi_pkg::COST_SPAN) * (NW'(infl) - NW'(d));
          den_nxt = NW'(infl - ins) << 7;
          k_nxt   = 3'd7;
          q_nxt   = '0;
          st_nxt  = B_DIV;
        end
      end
      B_DIV: begin
        // Restoring division, one quotient bit per cycle; the quotient stays below 210.
        if (num_r >= den_r) begin
          num_nxt = num_r - den_r;
          q_nxt   = q_r | (8'd1 << k_r);
        end
        den_nxt = den_r >> 1;
        k_nxt   = k_r - 3'd1;
        if (k_r == 3'd0) begin
          c_nxt  = cmoi_pkg::COST_BASE + ((num_r >= den_r) ? (q_r | 8'd1) : q_r);
          st_nxt = B_WR;
        end
      end
      B_WR: begin
        if (s_r == smax_r) begin
          done_nxt = 1'b1;
          st_nxt   = B_IDLE;
        end else begin
          s_nxt  = s_r + TW'(1);
          st_nxt = B_MUL;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_IDLE;
      done_r <= 1'b0;
      rad_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      rad_r  <= rad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    resq_r <= resq_nxt;
    acc_r  <= acc_nxt;
    s_r    <= s_nxt;
    smax_r <= smax_nxt;
    v_r    <= v_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    k_r    <= k_nxt;
    q_r    <= q_nxt;
    c_r    <= c_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_r == B_WR) begin
      tab[s_r] <= c_r;
    end
    rd_data_r <= tab[rd_addr];
  end

  assign done    = done_r;
  assign radius  = rad_r;
  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== design/costmap_obstacle_inflation.sv =====
// Costmap with obstacle inflation.
//
// One input stream carries operations: in_tuser selects mark, clear, inflate
// or read, and in_tdata carries the cell address, the mark value and the
// traversal limit. Every accepted transaction yields exactly one result on
// out_. The user writes registers through the cfg_ port while the block is
// idle; the block itself does not enforce this.
//
// A mark answers in the cycle after acceptance, a read after its memory read
// and the ST_RDOUT state, so marks can be taken every cycle while out_tready
// is high and a read holds off the next item while in ST_RDOUT. A clear
// sweeps the grid one cell per cycle. An inflate copies occupancy into cost,
// then, unless the inflation distance is zero, builds a cost table of 2*R*R+1
// distances in the shared square-root and divider unit, visits every grid cell
// (ST_ORG, ST_ORGCHK) and, around each obstacle, every window cell (a read-
// modify-write of the cost memory if in the grid). One item is in flight.
//
// After reset both memories are cleared in full, with in_tready low. A result
// waits in the output register while out_tready is low; the next item is
// accepted in the cycle that result is taken.
`default_nettype none
module costmap_obstacle_inflation #(
  parameter int unsigned MAX_WIDTH  = cmoi_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = cmoi_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_RADIUS = cmoi_pkg::DEF_MAX_RADIUS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cell_x[5:0], cell_y[11:6], mark_occupied[12], traverse_limit[20:13]
  input  wire logic [23:0] in_tdata,
  // func[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // cell_cost[7:0], cell_occupied[8], traversable[9], out_of_range[10]
  output logic [15:0]      out_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [cmoi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cmoi_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned TW    = $clog2(2*MAX_RADIUS*MAX_RADIUS + 1);
  localparam int unsigned EXW   = ((XW > RW + 1) ? XW : RW + 1) + 2;
  localparam int unsigned EYW   = ((YW > RW + 1) ? YW : RW + 1) + 2;
  localparam int unsigned CW    = cmoi_pkg::COST_W;

  typedef enum logic [9:0] {
    ST_INIT   = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_RDOUT  = 10'b0000000100,
    ST_CLR    = 10'b0000001000,
    ST_COPY   = 10'b0000010000,
    ST_COPY2  = 10'b0000100000,
    ST_LUT    = 10'b0001000000,
    ST_ORG    = 10'b0010000000,
    ST_ORGCHK = 10'b0100000000,
    ST_WIN    = 10'b1000000000
  } state_t;

  // Window update is a sub-phase of ST_WIN tracked by its own flag.
  state_t              state_r, state_nxt;
  logic                wupd_r, wupd_nxt;

  // Configuration registers.
  logic [cmoi_pkg::GRID_W-1:0] gw_r, gh_r;
  logic [cmoi_pkg::RES_W-1:0]  res_r;
  logic [cmoi_pkg::LEN_W-1:0]  infl_r, ins_r;

  logic [XW-1:0]       effw;
  logic [YW-1:0]       effh;
  logic [cmoi_pkg::RES_W-1:0] effres;

  // Input fields.
  cmoi_pkg::func_t     in_func;
  logic [cmoi_pkg::COORD_W-1:0] in_x, in_y;
  logic                in_mark;
  logic [CW-1:0]       in_lim;
  logic                in_inside;
  logic [AW-1:0]       in_addr;
  logic                accept;

  // Sweep, copy and scan counters.
  logic [AW-1:0]       sweep_r, sweep_nxt;
  logic                cp_v_r, cp_v_nxt;
  logic [AW-1:0]       cp_a_r, cp_a_nxt;
  logic [XW-1:0]       ox_r, ox_nxt;
  logic [YW-1:0]       oy_r, oy_nxt;
  logic [RW:0]         wx_r, wx_nxt, wy_r, wy_nxt;

  // Read item context.
  logic                rd_inside_r, rd_inside_nxt;
  logic [CW-1:0]       rd_lim_r, rd_lim_nxt;

  // Output register.
  logic                out_v_r, out_v_nxt, out_load;
  logic [10:0]         out_d_r, out_d_nxt;

  // Memory ports.
  logic                occ_we, occ_wd, occ_rd;
  logic [AW-1:0]       occ_wa, occ_ra;
  logic                cost_we;
  logic [AW-1:0]       cost_wa, cost_ra;
  logic [CW-1:0]       cost_wd, cost_rd;

  // Cost table.
  logic                lut_start, lut_done;
  logic [RW-1:0]       rad;
  logic [TW-1:0]       tab_ra;
  logic [CW-1:0]       tab_rd;

  // Window geometry.
  logic [RW:0]         two_r;
  logic [RW-1:0]       adx, ady;
  logic [EXW-1:0]      nxe;
  logic [EYW-1:0]      nye;
  logic                win_in;
  logic [AW-1:0]       win_addr, org_addr;
  logic                win_last, org_last, wx_last, ox_last;
  logic                sweeping;

  // Effective grid size and resolution.
  always_comb begin
    if (gw_r == '0) begin
      effw = XW'(1);
    end else if (32'(gw_r) > MAX_WIDTH) begin
      effw = XW'(MAX_WIDTH);
    end else begin
      effw = XW'(gw_r);
    end
    if (gh_r == '0) begin
      effh = YW'(1);
    end else if (32'(gh_r) > MAX_HEIGHT) begin
      effh = YW'(MAX_HEIGHT);
    end else begin
      effh = YW'(gh_r);
    end
    effres = (res_r == '0) ? cmoi_pkg::RES_W'(1) : res_r;
  end

  assign in_x      = in_tdata[5:0];
  assign in_y      = in_tdata[11:6];
  assign in_mark   = in_tdata[12];
  assign in_lim    = in_tdata[20:13];
  assign in_func   = cmoi_pkg::func_t'(in_tuser);
  assign in_inside = (32'(in_x) < 32'(effw)) && (32'(in_y) < 32'(effh));
  assign in_addr   = AW'(32'(in_y) * MAX_WIDTH + 32'(in_x));

  assign in_tready = (state_r == ST_IDLE) && (!out_v_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // Window offsets relative to the obstacle at (ox, oy).
  assign two_r = (RW+1)'(rad) << 1;
  assign adx   = (wx_r >= (RW+1)'(rad)) ? RW'(wx_r - (RW+1)'(rad)) : RW'((RW+1)'(rad) - wx_r);
  assign ady   = (wy_r >= (RW+1)'(rad)) ? RW'(wy_r - (RW+1)'(rad)) : RW'((RW+1)'(rad) - wy_r);
  assign tab_ra = TW'(32'(adx) * 32'(adx) + 32'(ady) * 32'(ady));
  assign nxe   = EXW'(ox_r) + EXW'(wx_r);
  assign nye   = EYW'(oy_r) + EYW'(wy_r);
  assign win_in = (nxe >= EXW'(rad)) && ((nxe - EXW'(rad)) < EXW'(effw)) &&
                  (nye >= EYW'(rad)) && ((nye - EYW'(rad)) < EYW'(effh));
  assign win_addr = AW'(32'(nye - EYW'(rad)) * MAX_WIDTH + 32'(nxe - EXW'(rad)));
  assign org_addr = AW'(32'(oy_r) * MAX_WIDTH + 32'(ox_r));

  assign wx_last  = (wx_r == two_r);
  assign win_last = wx_last && (wy_r == two_r);
  assign ox_last  = (ox_r == effw - XW'(1));
  assign org_last = ox_last && (oy_r == effh - YW'(1));
  assign sweeping = (state_r == ST_INIT) || (state_r == ST_CLR);

  always_comb begin
    state_nxt     = state_r;
    wupd_nxt      = 1'b0;
    sweep_nxt     = sweep_r;
    cp_v_nxt      = 1'b0;
    cp_a_nxt      = cp_a_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    wx_nxt        = wx_r;
    wy_nxt        = wy_r;
    rd_inside_nxt = rd_inside_r;
    rd_lim_nxt    = rd_lim_r;
    out_load      = 1'b0;
    out_d_nxt     = out_d_r;
    lut_start     = 1'b0;
    case (state_r)
      ST_INIT, ST_CLR: begin
        sweep_nxt = sweep_r + AW'(1);
        if (32'(sweep_r) == DEPTH - 1) begin
          sweep_nxt = '0;
          if (state_r == ST_INIT) begin
            state_nxt = ST_IDLE;
          end else begin
            out_load  = 1'b1;
            out_d_nxt = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            cmoi_pkg::FN_MARK: begin
              out_load  = 1'b1;
              out_d_nxt = {!in_inside, 10'd0};
            end
            cmoi_pkg::FN_CLEAR: begin
              sweep_nxt = '0;
              state_nxt = ST_CLR;
            end
            cmoi_pkg::FN_INFLATE: begin
              sweep_nxt = '0;
              state_nxt = ST_COPY;
            end
            cmoi_pkg::FN_READ: begin
              rd_inside_nxt = in_inside;
              rd_lim_nxt    = in_lim;
              state_nxt     = ST_RDOUT;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RDOUT: begin
        out_load = 1'b1;
        if (rd_inside_r) begin
          out_d_nxt = {1'b0, cost_rd < rd_lim_r, occ_rd, cost_rd};
        end else begin
          out_d_nxt = {1'b1, 10'd0};
        end
        state_nxt = ST_IDLE;
      end
      ST_COPY: begin
        cp_v_nxt  = 1'b1;
        cp_a_nxt  = sweep_r;
        sweep_nxt = sweep_r + AW'(1);
        if (32'(sweep_r) == DEPTH - 1) begin
          sweep_nxt = '0;
          state_nxt = ST_COPY2;
        end
      end
      ST_COPY2: begin
        if (infl_r == '0) begin
          out_load  = 1'b1;
          out_d_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          lut_start = 1'b1;
          state_nxt = ST_LUT;
        end
      end
      ST_LUT: begin
        if (lut_done) begin
          ox_nxt    = '0;
          oy_nxt    = '0;
          state_nxt = ST_ORG;
        end
      end
      ST_ORG: begin
        state_nxt = ST_ORGCHK;
      end
      ST_ORGCHK, ST_WIN: begin
        if (state_r == ST_ORGCHK && occ_rd) begin
          wx_nxt    = '0;
          wy_nxt    = '0;
          state_nxt = ST_WIN;
        end else if (state_r == ST_WIN && win_in && !wupd_r) begin
          // Read issued this cycle; compare and write back next cycle.
          wupd_nxt = 1'b1;
        end else if (state_r == ST_WIN && !win_last) begin
          if (wx_last) begin
            wx_nxt = '0;
            wy_nxt = wy_r + (RW+1)'(1);
          end else begin
            wx_nxt = wx_r + (RW+1)'(1);
          end
        end else if (org_last) begin
          out_load  = 1'b1;
          out_d_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_ORG;
          if (ox_last) begin
            ox_nxt = '0;
            oy_nxt = oy_r + YW'(1);
          end else begin
            ox_nxt = ox_r + XW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_v_nxt = out_load || (out_v_r && !out_tready);
  end

  // Memory port selection.
  always_comb begin
    occ_we  = 1'b0;
    occ_wa  = in_addr;
    occ_wd  = in_mark;
    cost_we = 1'b0;
    cost_wa = in_addr;
    cost_wd = in_mark ? cmoi_pkg::COST_LETHAL : cmoi_pkg::COST_FREE;
    occ_ra  = in_addr;
    cost_ra = in_addr;
    if (sweeping) begin
      occ_we  = 1'b1;
      occ_wa  = sweep_r;
      occ_wd  = 1'b0;
      cost_we = 1'b1;
      cost_wa = sweep_r;
      cost_wd = cmoi_pkg::COST_FREE;
    end else if (accept && in_func == cmoi_pkg::FN_MARK && in_inside) begin
      occ_we  = 1'b1;
      cost_we = 1'b1;
    end else if (cp_v_r) begin
      cost_we = 1'b1;
      cost_wa = cp_a_r;
      cost_wd = occ_rd ? cmoi_pkg::COST_LETHAL : cmoi_pkg::COST_FREE;
    end else if (wupd_r) begin
      cost_we = tab_rd > cost_rd;
      cost_wa = win_addr;
      cost_wd = tab_rd;
    end
    if (state_r == ST_COPY) begin
      occ_ra = sweep_r;
    end else if (state_r == ST_ORG) begin
      occ_ra = org_addr;
    end
    if (state_r == ST_WIN) begin
      cost_ra = win_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      wupd_r  <= 1'b0;
      sweep_r <= '0;
      cp_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      gw_r    <= cmoi_pkg::GRID_W'(64);
      gh_r    <= cmoi_pkg::GRID_W'(64);
      res_r   <= cmoi_pkg::RES_W'(50);
      infl_r  <= cmoi_pkg::LEN_W'(300);
      ins_r   <= cmoi_pkg::LEN_W'(150);
    end else begin
      state_r <= state_nxt;
      wupd_r  <= wupd_nxt;
      sweep_r <= sweep_nxt;
      cp_v_r  <= cp_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        case (cfg_index)
          cmoi_pkg::CFG_GRID_WIDTH:  gw_r   <= cfg_wdata[cmoi_pkg::GRID_W-1:0];
          cmoi_pkg::CFG_GRID_HEIGHT: gh_r   <= cfg_wdata[cmoi_pkg::GRID_W-1:0];
          cmoi_pkg::CFG_RESOLUTION:  res_r  <= cfg_wdata[cmoi_pkg::RES_W-1:0];
          cmoi_pkg::CFG_INFLATION:   infl_r <= cfg_wdata;
          cmoi_pkg::CFG_INSCRIBED:   ins_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_a_r      <= cp_a_nxt;
    ox_r        <= ox_nxt;
    oy_r        <= oy_nxt;
    wx_r        <= wx_nxt;
    wy_r        <= wy_nxt;
    rd_inside_r <= rd_inside_nxt;
    rd_lim_r    <= rd_lim_nxt;
    out_d_r     <= out_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_d_r};

  cmoi_grid_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_grid (
    .clk    (clk),
    .occ_we (occ_we),
    .occ_wa (occ_wa),
    .occ_wd (occ_wd),
    .occ_ra (occ_ra),
    .occ_rd (occ_rd),
    .cost_we(cost_we),
    .cost_wa(cost_wa),
    .cost_wd(cost_wd),
    .cost_ra(cost_ra),
    .cost_rd(cost_rd)
  );

  cmoi_ring_lut #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_lut (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lut_start),
    .res    (effres),
    .infl   (infl_r),
    .ins    (ins_r),
    .done   (lut_done),
    .radius (rad),
    .rd_addr(tab_ra),
    .rd_data(tab_rd)
  );

  // A result is never loaded over one that is still waiting.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_v_r || out_tready))
    else $error("result register overwritten");

  // A mark transaction answers in the next cycle.
  a_mark_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == cmoi_pkg::FN_MARK) |=> out_v_r)
    else $error("mark did not answer");

  // A window write-back always follows its read in the window phase.
  a_wupd_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    wupd_r |-> ($past(state_r == ST_WIN) && state_r == ST_WIN))
    else $error("window write-back out of sequence");

endmodule
`default_nettype wire
